[hdl/mfw_pkg.sv]
package mfw_pkg;

    // field and register widths
    localparam int OFF_W  = 16;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 8;
    localparam int AXIS_W = 32;
    localparam int WGT_W  = 32;

    // internal datapath widths
    localparam int DIST_W = 20;                      // distance, Q4.16
    localparam int SQ_W   = 2 * DIST_W;              // d*d before rounding
    localparam int D2_W   = 24;                      // d^2, Q8.16
    localparam int CUBE_W = D2_W + DIST_W;           // d2*d before rounding
    localparam int D3_W   = 28;                      // d^3, Q12.16
    localparam int COEF_W = 24;                      // cubic coefficients, Q.14
    localparam int P3_W   = COEF_W + D3_W + 1;
    localparam int P2_W   = COEF_W + D2_W + 1;
    localparam int P1_W   = COEF_W + DIST_W + 1;
    localparam int SUM_W  = 56;
    localparam int T_W    = SUM_W - 7;               // |sum| / 128
    localparam int PROD_W = 2 * AXIS_W;
    localparam int WQ_W   = PROD_W - 24;

    // pipeline depth
    localparam int LANE_STAGES  = 10;
    localparam int MERGE_STAGES = 3;
    localparam int PIPE_DEPTH   = LANE_STAGES + MERGE_STAGES;

    localparam int DEFAULT_COORD_FRAC_BITS = 12;

    localparam logic [DIST_W-1:0] DIST_ONE = 20'h10000;
    localparam logic [DIST_W-1:0] DIST_MAX = 20'hFFFFF;

    // floor(x/3) = (x * RECIP3) >> 20 for x < 2^19
    localparam logic [18:0] RECIP3 = 19'd349526;

    // axis clip thresholds on |sum|/128, ahead of the divide by three
    localparam logic [T_W-1:0] AXIS_BIG_POS = 49'd6442450944;
    localparam logic [T_W-1:0] AXIS_BIG_NEG = 49'd6442450947;

    localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] S32_MIN = 32'h8000_0000;

    // config reset values
    localparam logic [CFG_W-1:0] BLUR_B_RST = 16'd5461;
    localparam logic [CFG_W-1:0] RING_C_RST = 16'd5461;
    localparam logic [CFG_W-1:0] INV_R_RST  = 16'd2048;

    typedef enum logic [IDX_W-1:0] {
        REG_BLUR_B       = 8'd0,
        REG_RING_C       = 8'd1,
        REG_INV_RADIUS_X = 8'd2,
        REG_INV_RADIUS_Y = 8'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [CFG_W-1:0] blur_b;
        logic [CFG_W-1:0] ring_c;
    } shape_cfg_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] a3;
        logic signed [COEF_W-1:0] a2;
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a0;
    } coef_t;

    // Mitchell-Netravali cubic coefficients in Q.14 (times six)
    function automatic coef_t mfw_coeffs(input shape_cfg_t cfg, input logic far);
        logic signed [COEF_W-1:0] bs;
        logic signed [COEF_W-1:0] cs;
        coef_t r;
        bs = $signed({8'd0, cfg.blur_b});
        cs = $signed({8'd0, cfg.ring_c});
        if (far) begin
            r.a3 = -bs - 24'sd6 * cs;
            r.a2 = 24'sd6 * bs + 24'sd30 * cs;
            r.a1 = -(24'sd12 * bs) - 24'sd48 * cs;
            r.a0 = 24'sd8 * bs + 24'sd24 * cs;
        end else begin
            r.a3 = 24'sd196608 - 24'sd9 * bs - 24'sd6 * cs;
            r.a2 = -24'sd294912 + 24'sd12 * bs + 24'sd6 * cs;
            r.a1 = '0;
            r.a0 = 24'sd98304 - 24'sd2 * bs;
        end
        return r;
    endfunction

endpackage

[hdl/mfw_lane.sv]
module mfw_lane
    import mfw_pkg::*;
#(
    parameter int COORD_FRAC_BITS = DEFAULT_COORD_FRAC_BITS
) (
    input  logic                     aclk,
    input  logic [LANE_STAGES-1:0]   stage_en,
    input  logic signed [OFF_W-1:0]  offset,
    input  logic [CFG_W-1:0]         inv_radius,
    input  shape_cfg_t               shape_cfg,
    output logic signed [AXIS_W-1:0] axis_weight,
    output logic                     axis_sat
);

    localparam int SH      = 2 * COORD_FRAC_BITS - 16;
    localparam int RND_POS = (SH > 0) ? SH - 1 : 0;
    localparam logic [33:0] RND_ADD = (SH > 0) ? (34'd1 << RND_POS) : 34'd0;

    // stage 0: |offset| * inv_radius
    logic [OFF_W-1:0] mag;
    logic [31:0]      full_reg;

    // stage 1: doubled, rounded to Q.16, clipped distance
    logic [33:0]       full_rnd;
    logic [33:0]       du;
    logic              dclip;
    logic [DIST_W-1:0] d_s1_reg;
    logic              sat_s1_reg;

    // stage 2
    logic [SQ_W-1:0]   sq_reg;
    logic [DIST_W-1:0] d_s2_reg;
    logic              sat_s2_reg;

    // stage 3
    logic [SQ_W:0]       sq_rnd;
    logic [D2_W-1:0]     d2;
    logic [D2_W-1:0]     d2_reg;
    logic [CUBE_W-1:0]   cube_reg;
    logic [DIST_W-1:0]   d_s3_reg;
    logic                sat_s3_reg;

    // stage 4: polynomial terms
    logic [CUBE_W:0]          cube_rnd;
    logic [D3_W-1:0]          d3;
    coef_t                    coef;
    logic signed [P3_W-1:0]   p3_reg;
    logic signed [P2_W-1:0]   p2_reg;
    logic signed [P1_W-1:0]   p1_reg;
    logic signed [COEF_W-1:0] a0_reg;
    logic                     sat_s4_reg;

    // stages 5, 6: adder tree
    logic signed [SUM_W-1:0] sa_reg;
    logic signed [SUM_W-1:0] sb_reg;
    logic                    sat_s5_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic                    sat_s6_reg;

    // stage 7: magnitude with rounding, over 128
    logic [SUM_W-1:0] sum_mag;
    logic [SUM_W-1:0] sum_rnd;
    logic [T_W-1:0]   t_reg;
    logic             neg_s7_reg;
    logic             sat_s7_reg;

    // stage 8: upper digit of the divide by three
    logic        big;
    logic [16:0] hi;
    logic [35:0] hi_prod;
    logic [15:0] qh;
    logic [16:0] hi_rem;
    logic [15:0] qh_reg;
    logic [17:0] rl_reg;
    logic        big_reg;
    logic        neg_s8_reg;
    logic        sat_s8_reg;

    // stage 9: lower digit, sign, clip
    logic [36:0] lo_prod;
    logic [31:0] q;
    logic [31:0] q_neg;

    always_comb begin
        mag = offset[OFF_W-1] ? (~offset + 16'd1) : offset;

        full_rnd = {1'b0, full_reg, 1'b0} + RND_ADD;
        du       = full_rnd >> SH;
        dclip    = du > {14'd0, DIST_MAX};

        sq_rnd = {1'b0, sq_reg} + 41'd32768;
        d2     = sq_rnd[SQ_W-1:16];

        cube_rnd = {1'b0, cube_reg} + 45'd32768;
        d3       = cube_rnd[CUBE_W-1:16];
        coef     = mfw_coeffs(shape_cfg, d_s3_reg > DIST_ONE);

        sum_mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        sum_rnd = sum_mag + 56'd192;

        big     = neg_s7_reg ? (t_reg >= AXIS_BIG_NEG) : (t_reg >= AXIS_BIG_POS);
        hi      = t_reg[32:16];
        hi_prod = hi * RECIP3;
        qh      = hi_prod[35:20];
        hi_rem  = hi - {qh, 1'b0} - {1'b0, qh};

        lo_prod = rl_reg * RECIP3;
        q       = {qh_reg, 16'd0} + {16'd0, lo_prod[35:20]};
        q_neg   = ~q + 32'd1;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            full_reg <= mag * inv_radius;
        end
        if (stage_en[1]) begin
            d_s1_reg   <= dclip ? DIST_MAX : du[DIST_W-1:0];
            sat_s1_reg <= dclip;
        end
        if (stage_en[2]) begin
            sq_reg     <= d_s1_reg * d_s1_reg;
            d_s2_reg   <= d_s1_reg;
            sat_s2_reg <= sat_s1_reg;
        end
        if (stage_en[3]) begin
            d2_reg     <= d2;
            cube_reg   <= d2 * d_s2_reg;
            d_s3_reg   <= d_s2_reg;
            sat_s3_reg <= sat_s2_reg;
        end
        if (stage_en[4]) begin
            p3_reg     <= coef.a3 * $signed({1'b0, d3});
            p2_reg     <= coef.a2 * $signed({1'b0, d2_reg});
            p1_reg     <= coef.a1 * $signed({1'b0, d_s3_reg});
            a0_reg     <= coef.a0;
            sat_s4_reg <= sat_s3_reg;
        end
        if (stage_en[5]) begin
            sa_reg     <= SUM_W'(p3_reg) + SUM_W'(p2_reg);
            sb_reg     <= SUM_W'(p1_reg) + (SUM_W'(a0_reg) <<< 16);
            sat_s5_reg <= sat_s4_reg;
        end
        if (stage_en[6]) begin
            sum_reg    <= sa_reg + sb_reg;
            sat_s6_reg <= sat_s5_reg;
        end
        if (stage_en[7]) begin
            t_reg      <= sum_rnd[SUM_W-1:7];
            neg_s7_reg <= sum_reg[SUM_W-1];
            sat_s7_reg <= sat_s6_reg;
        end
        if (stage_en[8]) begin
            qh_reg     <= qh;
            rl_reg     <= {hi_rem[1:0], t_reg[15:0]};
            big_reg    <= big;
            neg_s8_reg <= neg_s7_reg;
            sat_s8_reg <= sat_s7_reg;
        end
        if (stage_en[9]) begin
            if (big_reg) begin
                axis_weight <= neg_s8_reg ? $signed(S32_MIN) : $signed(S32_MAX);
            end else begin
                axis_weight <= neg_s8_reg ? $signed(q_neg) : $signed(q);
            end
            axis_sat <= sat_s8_reg | big_reg;
        end
    end

endmodule

[hdl/mfw_merge.sv]
module mfw_merge
    import mfw_pkg::*;
(
    input  logic                     aclk,
    input  logic [MERGE_STAGES-1:0]  stage_en,
    input  logic signed [AXIS_W-1:0] wx,
    input  logic signed [AXIS_W-1:0] wy,
    input  logic                     sat_x,
    input  logic                     sat_y,
    output logic signed [WGT_W-1:0]  weight,
    output logic                     saturated
);

    logic signed [PROD_W-1:0] prod_reg;
    logic                     sat_p_reg;

    logic [PROD_W-1:0] prod_mag;
    logic [PROD_W-1:0] prod_rnd;
    logic [WQ_W-1:0]   q_reg;
    logic              neg_reg;
    logic              sat_q_reg;

    logic              clip;
    logic [WQ_W-1:0]   q_neg;

    always_comb begin
        prod_mag = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
        prod_rnd = prod_mag + (64'd1 << 23);
        clip     = neg_reg ? (q_reg > 40'h80000000) : (q_reg > 40'h7FFFFFFF);
        q_neg    = ~q_reg + 40'd1;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            prod_reg  <= wx * wy;
            sat_p_reg <= sat_x | sat_y;
        end
        if (stage_en[1]) begin
            q_reg     <= prod_rnd[PROD_W-1:24];
            neg_reg   <= prod_reg[PROD_W-1];
            sat_q_reg <= sat_p_reg;
        end
        if (stage_en[2]) begin
            if (clip) begin
                weight <= neg_reg ? $signed(S32_MIN) : $signed(S32_MAX);
            end else begin
                weight <= neg_reg ? $signed(q_neg[WGT_W-1:0]) : $signed(q_reg[WGT_W-1:0]);
            end
            saturated <= sat_q_reg | clip;
        end
    end

endmodule

[hdl/mitchell_filter_weight_top.sv]
// Separable Mitchell-Netravali filter weight. Each transfer on the s_ side
// carries a signed offset pair; each transfer on the m_ side returns the
// Q8.24 weight wx*wy and a flag that is set when the distance, an axis value
// or the weight was clipped. Results come out in input order. Throughput is
// one offset pair per cycle unless m_ready is low with every slot full; each
// axis lane has 10 stages (distance scale, d^2 and d^3 multipliers, cubic
// terms, adder tree, two-digit divide by three), then the merge unit has 3
// stages for the 32x32 product and its rounding. Every stage has its own
// valid bit and loads when it or a later stage has an empty slot or the
// output drains, so s_ready stays high while any slot is empty, even with a
// result parked on m_ side. The config port is always ready; write registers
// only while no transfer is in flight. Index 0 blur_b, 1 ring_c,
// 2 inv_radius_x, 3 inv_radius_y; other indexes are ignored.
module mitchell_filter_weight_top
    import mfw_pkg::*;
#(
    parameter int COORD_FRAC_BITS = DEFAULT_COORD_FRAC_BITS
) (
    input  logic                    aclk,
    input  logic                    aresetn,

    // config write channel
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,

    // offset input
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [OFF_W-1:0] s_offset_x,
    input  logic signed [OFF_W-1:0] s_offset_y,

    // weight output
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [WGT_W-1:0] m_weight,
    output logic                    m_saturated
);

    // configuration registers
    logic [CFG_W-1:0] blur_b_reg;
    logic [CFG_W-1:0] ring_c_reg;
    logic [CFG_W-1:0] inv_radius_x_reg;
    logic [CFG_W-1:0] inv_radius_y_reg;
    shape_cfg_t       shape_cfg;

    // per-stage valid bits and advance enables
    logic [PIPE_DEPTH-1:0] v_reg;
    logic [PIPE_DEPTH-1:0] v_next;
    logic [PIPE_DEPTH-1:0] stage_en;

    // lane results
    logic signed [AXIS_W-1:0] wx;
    logic signed [AXIS_W-1:0] wy;
    logic                     sat_x;
    logic                     sat_y;

    assign cfg_ready = 1'b1;
    assign shape_cfg = '{blur_b: blur_b_reg, ring_c: ring_c_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blur_b_reg       <= BLUR_B_RST;
            ring_c_reg       <= RING_C_RST;
            inv_radius_x_reg <= INV_R_RST;
            inv_radius_y_reg <= INV_R_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_BLUR_B:       blur_b_reg       <= cfg_data;
                REG_RING_C:       ring_c_reg       <= cfg_data;
                REG_INV_RADIUS_X: inv_radius_x_reg <= cfg_data;
                REG_INV_RADIUS_Y: inv_radius_y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // A stage may load when it, or any stage after it, has an empty slot,
    // or when the output is being drained this cycle.
    always_comb begin
        logic [PIPE_DEPTH-1:0] later;
        for (int k = 0; k < PIPE_DEPTH; k++) begin
            later       = {PIPE_DEPTH{1'b1}} << k;
            stage_en[k] = m_ready || ((~v_reg & later) != '0);
        end
        v_next[0] = stage_en[0] ? s_valid : v_reg[0];
        for (int k = 1; k < PIPE_DEPTH; k++) begin
            v_next[k] = stage_en[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    assign s_ready = stage_en[0];
    assign m_valid = v_reg[PIPE_DEPTH-1];

    mfw_lane #(
        .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_lane_x (
        .aclk        (aclk),
        .stage_en    (stage_en[LANE_STAGES-1:0]),
        .offset      (s_offset_x),
        .inv_radius  (inv_radius_x_reg),
        .shape_cfg   (shape_cfg),
        .axis_weight (wx),
        .axis_sat    (sat_x)
    );

    mfw_lane #(
        .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_lane_y (
        .aclk        (aclk),
        .stage_en    (stage_en[LANE_STAGES-1:0]),
        .offset      (s_offset_y),
        .inv_radius  (inv_radius_y_reg),
        .shape_cfg   (shape_cfg),
        .axis_weight (wy),
        .axis_sat    (sat_y)
    );

    mfw_merge u_merge (
        .aclk      (aclk),
        .stage_en  (stage_en[PIPE_DEPTH-1:LANE_STAGES]),
        .wx        (wx),
        .wy        (wy),
        .sat_x     (sat_x),
        .sat_y     (sat_y),
        .weight    (m_weight),
        .saturated (m_saturated)
    );

endmodule

[hdl/mfw_checker.sv]
module mfw_checker
    import mfw_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic signed [WGT_W-1:0] m_weight,
    input logic                    m_saturated
);

    localparam int OCC_W = $clog2(PIPE_DEPTH + 1);

    // transfers in minus transfers out
    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;

    always_comb begin
        occ_next = occ_reg;
        if (s_valid && s_ready) begin
            occ_next = occ_next + OCC_W'(1);
        end
        if (m_valid && m_ready) begin
            occ_next = occ_next - OCC_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_weight) && $stable(m_saturated))
        else $error("result changed while stalled");

    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> occ_reg != '0)
        else $error("result with nothing in flight");

    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= OCC_W'(PIPE_DEPTH))
        else $error("more items in flight than pipeline slots");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg == '0 |-> s_ready)
        else $error("input stalled with empty pipeline");

endmodule

bind mitchell_filter_weight_top mfw_checker u_mfw_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_weight    (m_weight),
    .m_saturated (m_saturated)
);
